### rtl/core/adc_ladder_key_press_classifier_assert.svh
// Assertion macros used by the keypad classifier checker.
`ifndef ADC_LADDER_KEY_PRESS_CLASSIFIER_ASSERT_SVH
`define ADC_LADDER_KEY_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ALKPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("alkpc assertion failed");

// Next-cycle implication, disabled while in reset.
`define ALKPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("alkpc assertion failed");

`endif

### rtl/core/alkpc_pkg.sv
// Package: widths, key levels, event and register codes of the keypad classifier.
`timescale 1ns / 1ps
package alkpc_pkg;

  localparam int unsigned SampleBits = 10;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned TolBits    = 9;
  localparam int unsigned ThrBits    = 16;
  localparam int unsigned KeyBits    = 3;
  localparam int unsigned EventBits  = 3;
  localparam int unsigned NumLevels  = 5;
  // bits of the highest ladder level
  localparam int unsigned LevelTopBits = 10;
  localparam int unsigned LevelBits  =
      ((SampleBits > LevelTopBits) ? SampleBits : LevelTopBits) + 1;
  localparam int unsigned CmpBits    = (CountBits > ThrBits) ? CountBits : ThrBits;
  localparam int unsigned AddrBits   = 4;
  localparam int unsigned DataBits   = 32;
  localparam int unsigned InBytes    = (SampleBits + 7) / 8;
  localparam int unsigned OutBits    = 2 * KeyBits + 2;
  localparam int unsigned OutBytes   = (OutBits + 7) / 8;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [CountBits-1:0]  count_t;
  typedef logic [KeyBits-1:0]    key_t;

  // Ladder levels of keys 2..6
  localparam logic [LevelBits-1:0] KeyLevels [NumLevels] = '{
    LevelBits'(109), LevelBits'(287), LevelBits'(473), LevelBits'(631), LevelBits'(755)
  };

  localparam key_t KeyNone  = KeyBits'(0);
  localparam key_t KeyFirst = KeyBits'(1);

  typedef enum logic [EventBits-1:0] {
    EvNone      = 3'd0,
    EvShortHeld = 3'd1,
    EvLongHeld  = 3'd2,
    EvShortRel  = 3'd3,
    EvLongRel   = 3'd4
  } press_event_e;

  localparam logic [1:0] RegTolerance = 2'd0;
  localparam logic [1:0] RegShort     = 2'd1;
  localparam logic [1:0] RegLong      = 2'd2;

  localparam logic [TolBits-1:0] TolReset   = TolBits'(60);
  localparam logic [ThrBits-1:0] ShortReset = ThrBits'(3);
  localparam logic [ThrBits-1:0] LongReset  = ThrBits'(100);

endpackage

### rtl/core/alkpc_key_decode.sv
// Ladder sample to key number decoder (windows around fixed levels).
`timescale 1ns / 1ps
module alkpc_key_decode (
  input  alkpc_pkg::sample_t             sample_i,
  input  logic [alkpc_pkg::TolBits-1:0]  tol_i,
  output alkpc_pkg::key_t                key_o
);

  logic [alkpc_pkg::LevelBits-1:0] s_ext;
  logic [alkpc_pkg::LevelBits-1:0] t_ext;

  assign s_ext = alkpc_pkg::LevelBits'(sample_i);
  assign t_ext = alkpc_pkg::LevelBits'(tol_i);

  // lowest key wins: scan levels from the top so lower ones overwrite
  always_comb begin
    key_o = alkpc_pkg::KeyNone;
    for (int i = alkpc_pkg::NumLevels - 1; i >= 0; i--) begin
      if ((s_ext <= alkpc_pkg::KeyLevels[i] + t_ext) &&
          (s_ext + t_ext >= alkpc_pkg::KeyLevels[i])) begin
        key_o = alkpc_pkg::KeyBits'(i + 2);
      end
    end
    if (s_ext <= t_ext) begin
      key_o = alkpc_pkg::KeyFirst;
    end
  end

endmodule

### rtl/core/adc_ladder_key_press_classifier.sv
// Top level: resistor-ladder keypad classifier with short and long press tracking.
//
// One ADC sample per item in, one result item out per sample. The block takes a
// new item every cycle: the sample lands in an input register, the key decode and
// the held-key/counter update are combinational, and the result lands in an output
// register, so throughput is 1 item per cycle, limited only by the output side
// taking results. Thresholds and the window tolerance are set over the APB port;
// write them only while no item is in flight.
`timescale 1ns / 1ps
module adc_ladder_key_press_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [alkpc_pkg::AddrBits-1:0]     paddr,
  input  logic [alkpc_pkg::DataBits-1:0]     pwdata,
  output logic [alkpc_pkg::DataBits-1:0]     prdata,
  output logic                               pready,
  // sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [8*alkpc_pkg::InBytes-1:0]    s_axis_tdata,  // [9:0] adc_sample
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] key_id, [5:3] press_event, [6] send_key_down, [7] send_long_down
  output logic [8*alkpc_pkg::OutBytes-1:0]   m_axis_tdata
);

  localparam alkpc_pkg::count_t CountMax = '1;

  // configuration
  logic [alkpc_pkg::TolBits-1:0] tol_q;
  logic [alkpc_pkg::ThrBits-1:0] short_q;
  logic [alkpc_pkg::ThrBits-1:0] long_q;
  logic                          cfg_wr;

  // pipeline
  logic                  in_valid_q;
  alkpc_pkg::sample_t    in_sample_q;
  logic                  out_valid_q;
  alkpc_pkg::key_t       out_key_q;
  alkpc_pkg::press_event_e out_event_q;
  logic                  out_down_q;
  logic                  out_long_q;
  logic                  out_free;
  logic                  advance;

  // tracker state
  alkpc_pkg::key_t   held_key_q, held_key_d;
  alkpc_pkg::count_t hold_count_q, hold_count_d;
  logic              down_sent_q, down_sent_d;
  logic              long_sent_q, long_sent_d;

  alkpc_pkg::key_t         key_seen;
  alkpc_pkg::count_t       count_inc;
  logic [alkpc_pkg::CmpBits-1:0] inc_ext, cur_ext, short_ext, long_ext;
  alkpc_pkg::press_event_e ev;
  alkpc_pkg::key_t         ev_key;
  logic                    snd_down, snd_long;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= alkpc_pkg::TolReset;
      short_q <= alkpc_pkg::ShortReset;
      long_q  <= alkpc_pkg::LongReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        alkpc_pkg::RegTolerance: tol_q   <= pwdata[alkpc_pkg::TolBits-1:0];
        alkpc_pkg::RegShort:     short_q <= pwdata[alkpc_pkg::ThrBits-1:0];
        alkpc_pkg::RegLong:      long_q  <= pwdata[alkpc_pkg::ThrBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      alkpc_pkg::RegTolerance: prdata = alkpc_pkg::DataBits'(tol_q);
      alkpc_pkg::RegShort:     prdata = alkpc_pkg::DataBits'(short_q);
      alkpc_pkg::RegLong:      prdata = alkpc_pkg::DataBits'(long_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= advance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample_q <= s_axis_tdata[alkpc_pkg::SampleBits-1:0];
    end
  end

  // ---------------- decode and tracking ----------------
  alkpc_key_decode u_decode (
    .sample_i (in_sample_q),
    .tol_i    (tol_q),
    .key_o    (key_seen)
  );

  assign count_inc = (hold_count_q == CountMax) ? hold_count_q : hold_count_q + 1'b1;
  assign inc_ext   = alkpc_pkg::CmpBits'(count_inc);
  assign cur_ext   = alkpc_pkg::CmpBits'(hold_count_q);
  assign short_ext = alkpc_pkg::CmpBits'(short_q);
  assign long_ext  = alkpc_pkg::CmpBits'(long_q);

  always_comb begin
    held_key_d   = held_key_q;
    hold_count_d = hold_count_q;
    down_sent_d  = down_sent_q;
    long_sent_d  = long_sent_q;
    ev           = alkpc_pkg::EvNone;
    ev_key       = alkpc_pkg::KeyNone;
    snd_down     = 1'b0;
    snd_long     = 1'b0;

    if (key_seen != alkpc_pkg::KeyNone && held_key_q == alkpc_pkg::KeyNone) begin
      held_key_d = key_seen;
    end else if (key_seen != alkpc_pkg::KeyNone && key_seen == held_key_q) begin
      hold_count_d = count_inc;
      ev_key       = held_key_q;
      if (inc_ext > short_ext && long_ext > inc_ext) begin
        ev = alkpc_pkg::EvShortHeld;
      end else if (inc_ext > long_ext) begin
        ev = alkpc_pkg::EvLongHeld;
      end
    end else if (held_key_q != alkpc_pkg::KeyNone) begin
      // release or key change
      ev_key       = held_key_q;
      hold_count_d = '0;
      held_key_d   = alkpc_pkg::KeyNone;
      if (cur_ext > short_ext && long_ext > cur_ext) begin
        ev = alkpc_pkg::EvShortRel;
      end else if (cur_ext > long_ext) begin
        ev = alkpc_pkg::EvLongRel;
      end
    end

    case (ev)
      alkpc_pkg::EvShortHeld: begin
        snd_down    = !down_sent_q;
        down_sent_d = 1'b1;
      end
      alkpc_pkg::EvLongHeld: begin
        snd_long    = !long_sent_q;
        long_sent_d = 1'b1;
      end
      alkpc_pkg::EvShortRel, alkpc_pkg::EvLongRel: begin
        down_sent_d = 1'b0;
        long_sent_d = 1'b0;
      end
      default: ;
    endcase

    if (ev == alkpc_pkg::EvNone) begin
      ev_key = alkpc_pkg::KeyNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_key_q   <= alkpc_pkg::KeyNone;
      hold_count_q <= '0;
      down_sent_q  <= 1'b0;
      long_sent_q  <= 1'b0;
    end else if (advance) begin
      held_key_q   <= held_key_d;
      hold_count_q <= hold_count_d;
      down_sent_q  <= down_sent_d;
      long_sent_q  <= long_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_key_q   <= ev_key;
      out_event_q <= ev;
      out_down_q  <= snd_down;
      out_long_q  <= snd_long;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = (8*alkpc_pkg::OutBytes)'({out_long_q, out_down_q,
                                                   out_event_q, out_key_q});

endmodule

### rtl/core/alkpc_checker.sv
// Port-level checker for the keypad classifier, bound to the top level.
`timescale 1ns / 1ps
`include "adc_ladder_key_press_classifier_assert.svh"
module alkpc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [8*alkpc_pkg::OutBytes-1:0]  m_axis_tdata
);

  logic [alkpc_pkg::KeyBits-1:0]   o_key;
  logic [alkpc_pkg::EventBits-1:0] o_event;

  assign o_key   = m_axis_tdata[2:0];
  assign o_event = m_axis_tdata[5:3];

  // no event means an all-zero result
  `ALKPC_ASSERT_IMPL(a_none_is_zero, clk_i, rst_ni,
    m_axis_tvalid && o_event == alkpc_pkg::EvNone, m_axis_tdata == '0)

  // an event always names a real key
  `ALKPC_ASSERT_IMPL(a_event_has_key, clk_i, rst_ni,
    m_axis_tvalid && o_event != alkpc_pkg::EvNone, o_key != 3'd0 && o_key != 3'd7)

  // message strobes only ride on their hold events
  `ALKPC_ASSERT_IMPL(a_strobe_event, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tdata[6] || m_axis_tdata[7]),
    (!m_axis_tdata[6] || o_event == alkpc_pkg::EvShortHeld) &&
    (!m_axis_tdata[7] || o_event == alkpc_pkg::EvLongHeld))

  // a stalled result holds
  `ALKPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind adc_ladder_key_press_classifier alkpc_checker u_alkpc_checker (.*);
